### rtl/grid_index_walker_assert.svh
// Assertion shorthands for the checker of this block.
`ifndef GRID_INDEX_WALKER_ASSERT_SVH
`define GRID_INDEX_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GIW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GIW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gidx_pkg.sv
package gidx_pkg;

  // Grid shape
  localparam int NUM_AXES   = 3;
  localparam int MAX_EXTENT = 1024;

  // Field widths
  localparam int EXT_W    = 11;   // extent registers and axis 0
  localparam int AXIS_W   = 10;   // axes 1 and 2
  localparam int FLAT_W   = 31;   // flat index
  localparam int PLANE_W  = 21;   // e1*e2 and partial flat sums
  localparam int STRIDE_W = 32;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Restoring divide: quotient bits per division
  localparam int DIV_STEPS = 11;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS2 = 2'd2;

  // Shared arithmetic unit operations
  typedef logic alu_op_t;
  localparam alu_op_t ALU_MAC  = 1'b0;   // a*b + c
  localparam alu_op_t ALU_CSUB = 1'b1;   // a >= b ? a-b : a

  // Register value to effective extent: 0 counts as 1, clamp at MAX_EXTENT
  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = EXT_W'(1);
    end else if (32'(v) > MAX_EXTENT) begin
      r = EXT_W'(MAX_EXTENT);
    end
    return r;
  endfunction

endpackage

### rtl/gidx_alu.sv
module gidx_alu (
  input  gidx_pkg::alu_op_t                op,
  input  logic [gidx_pkg::FLAT_W-1:0]      a,
  input  logic [gidx_pkg::FLAT_W-1:0]      b,
  input  logic [gidx_pkg::AXIS_W-1:0]      c,
  output logic [gidx_pkg::FLAT_W-1:0]      res,
  output logic                             ge
);
  import gidx_pkg::*;

  logic [PLANE_W+EXT_W-1:0] prod;
  logic [PLANE_W+EXT_W-1:0] mac;
  logic [FLAT_W:0]          diff;

  // Multiply-add on the narrow operand slices
  assign prod = a[PLANE_W-1:0] * b[EXT_W-1:0];
  assign mac  = prod + (PLANE_W+EXT_W)'(c);

  // Compare-subtract for one restoring divide step
  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[FLAT_W];

  always_comb begin
    case (op)
      ALU_MAC:  res = mac[FLAT_W-1:0];
      ALU_CSUB: res = ge ? diff[FLAT_W-1:0] : a;
      default:  res = a;
    endcase
  end

endmodule

### rtl/grid_index_walker.sv
// Row-major index walker over a grid of up to three configured axes. An item
// is taken when start is high and busy is low; one result follows, shown for
// exactly one cycle with done high, and it cannot be held off, so the
// receiver must take it in that cycle. Every item runs through one shared
// multiply-add / compare-subtract unit under a small sequencer. Each item forms
// the grid total and the current flat index; loads and steps then form the new
// flat index, stride moves run two 11-step restoring divisions by e1*e2 and
// by e2 unless the new flat index is negative or above the total, and unknown
// modes do neither. busy falls as done rises. Extent registers are written
// through the cfg channel, which is always ready; write them only while the
// block is idle. A refused move reports range_error and keeps the old position.
module grid_index_walker (
  input  logic                               clk,
  input  logic                               rst,
  // item command
  input  logic                               start,
  output logic                               busy,
  input  logic [gidx_pkg::MODE_W-1:0]        mode,
  input  logic signed [gidx_pkg::STRIDE_W-1:0] stride,
  input  logic [gidx_pkg::EXT_W-1:0]         load_axis0,
  input  logic [gidx_pkg::AXIS_W-1:0]        load_axis1,
  input  logic [gidx_pkg::AXIS_W-1:0]        load_axis2,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gidx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gidx_pkg::EXT_W-1:0]         cfg_data,
  // result
  output logic                               done,
  output logic [gidx_pkg::EXT_W-1:0]         pos_axis0,
  output logic [gidx_pkg::AXIS_W-1:0]        pos_axis1,
  output logic [gidx_pkg::AXIS_W-1:0]        pos_axis2,
  output logic [gidx_pkg::FLAT_W-1:0]        flat_position,
  output logic                               in_grid,
  output logic                               range_error
);
  import gidx_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TOT1 = 4'd1;
  localparam logic [3:0] ST_TOT2 = 4'd2;
  localparam logic [3:0] ST_CUR1 = 4'd3;
  localparam logic [3:0] ST_CUR2 = 4'd4;
  localparam logic [3:0] ST_NEW1 = 4'd5;
  localparam logic [3:0] ST_NEW2 = 4'd6;
  localparam logic [3:0] ST_ADD  = 4'd7;
  localparam logic [3:0] ST_DIV1 = 4'd8;
  localparam logic [3:0] ST_DIV2 = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  localparam int        SUM_W    = FLAT_W + 3;
  localparam logic [3:0] CNT_LAST = 4'(DIV_STEPS - 1);

  logic [3:0]              state;
  logic [EXT_W-1:0]        ext0, ext1, ext2;
  logic [EXT_W-1:0]        e0, e1, e2;
  logic [EXT_W-1:0]        pos0;
  logic [AXIS_W-1:0]       pos1, pos2;
  logic [EXT_W-1:0]        n0;
  logic [AXIS_W-1:0]       n1, n2;
  logic [MODE_W-1:0]       mode_r;
  logic [STRIDE_W-1:0]     stride_r;
  logic [PLANE_W-1:0]      plane, acc;
  logic [FLAT_W-1:0]       total, flat_cur, flat_new;
  logic [FLAT_W-1:0]       rem, dvs;
  logic [DIV_STEPS-1:0]    quo;
  logic [3:0]              cnt;
  logic                    err_r, chk_r, change_r;

  // effective extents
  assign e0 = eff_extent(ext0);
  assign e1 = eff_extent(ext1);
  assign e2 = (NUM_AXES < 3) ? EXT_W'(1) : eff_extent(ext2);

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Candidate position for load and single steps, taken at accept
  logic [EXT_W-1:0]  inc2, inc1, min2, min1, dec2, dec1;
  logic              f2_wrap, f1_wrap, b2_zero, b1_zero;
  logic [AXIS_W-1:0] ld_n2;
  logic [EXT_W-1:0]  step_n0;
  logic [AXIS_W-1:0] step_n1, step_n2;
  logic              step_err;

  always_comb begin
    inc2    = {1'b0, pos2} + EXT_W'(1);
    inc1    = {1'b0, pos1} + EXT_W'(1);
    f2_wrap = (inc2 >= e2);
    f1_wrap = (inc1 >= e1);
    b2_zero = (pos2 == '0);
    b1_zero = (pos1 == '0);
    min2    = ({1'b0, pos2} > e2) ? e2 : {1'b0, pos2};
    min1    = ({1'b0, pos1} > e1) ? e1 : {1'b0, pos1};
    dec2    = b2_zero ? (e2 - EXT_W'(1)) : (min2 - EXT_W'(1));
    dec1    = b1_zero ? (e1 - EXT_W'(1)) : (min1 - EXT_W'(1));
    ld_n2   = (NUM_AXES < 3) ? '0 : load_axis2;
    step_n0  = pos0;
    step_n1  = pos1;
    step_n2  = pos2;
    step_err = 1'b0;
    case (mode)
      MODE_LOAD: begin
        step_n0  = load_axis0;
        step_n1  = load_axis1;
        step_n2  = ld_n2;
        step_err = ({1'b0, load_axis1} >= e1) || ({1'b0, ld_n2} >= e2);
      end
      MODE_FWD: begin
        // carry from the fastest axis toward axis 0
        step_n2 = f2_wrap ? '0 : inc2[AXIS_W-1:0];
        if (f2_wrap) begin
          step_n1 = f1_wrap ? '0 : inc1[AXIS_W-1:0];
          if (f1_wrap) begin
            step_n0 = pos0 + EXT_W'(1);
          end
        end
      end
      MODE_BACK: begin
        // borrow; refused when axis 0 would go below zero
        step_n2 = dec2[AXIS_W-1:0];
        if (b2_zero) begin
          step_n1 = dec1[AXIS_W-1:0];
          if (b1_zero) begin
            step_err = (pos0 == '0);
            step_n0  = pos0 - EXT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Shared arithmetic unit operand select
  alu_op_t           alu_op;
  logic [FLAT_W-1:0] alu_a, alu_b, alu_res;
  logic [AXIS_W-1:0] alu_c;
  logic              alu_ge;

  always_comb begin
    alu_op = ALU_MAC;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    case (state)
      ST_TOT1: begin
        alu_a = FLAT_W'(e1);
        alu_b = FLAT_W'(e2);
      end
      ST_TOT2: begin
        alu_a = FLAT_W'(plane);
        alu_b = FLAT_W'(e0);
      end
      ST_CUR1: begin
        alu_a = FLAT_W'(pos0);
        alu_b = FLAT_W'(e1);
        alu_c = pos1;
      end
      ST_CUR2: begin
        alu_a = FLAT_W'(acc);
        alu_b = FLAT_W'(e2);
        alu_c = pos2;
      end
      ST_NEW1: begin
        alu_a = FLAT_W'(n0);
        alu_b = FLAT_W'(e1);
        alu_c = n1;
      end
      ST_NEW2: begin
        alu_a = FLAT_W'(acc);
        alu_b = FLAT_W'(e2);
        alu_c = n2;
      end
      ST_DIV1, ST_DIV2: begin
        alu_op = ALU_CSUB;
        alu_a  = rem;
        alu_b  = dvs;
      end
      default: begin
      end
    endcase
  end

  gidx_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // Stride move: flat index plus or minus the signed stride
  logic signed [SUM_W-1:0] f_sum;
  logic                    f_bad;

  always_comb begin
    if (mode_r == MODE_ADD) begin
      f_sum = $signed({3'b000, flat_cur}) + SUM_W'($signed(stride_r));
    end else begin
      f_sum = $signed({3'b000, flat_cur}) - SUM_W'($signed(stride_r));
    end
    f_bad = f_sum[SUM_W-1] || (f_sum > $signed({3'b000, total}));
  end

  // Quotient with this step's bit shifted in
  logic [DIV_STEPS-1:0] quo_next;
  assign quo_next = {quo[DIV_STEPS-2:0], alu_ge};

  // Final decision and chosen position
  logic              err_fin, commit;
  logic [EXT_W-1:0]  sel0;
  logic [AXIS_W-1:0] sel1, sel2;

  always_comb begin
    err_fin = err_r || (chk_r && (flat_new > total));
    commit  = change_r && !err_fin;
    sel0    = commit ? n0 : pos0;
    sel1    = commit ? n1 : pos1;
    sel2    = commit ? n2 : pos2;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ext0 <= EXT_W'(1);
      ext1 <= EXT_W'(1);
      ext2 <= EXT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXTENT_AXIS0: ext0 <= cfg_data;
        REG_EXTENT_AXIS1: ext1 <= cfg_data;
        REG_EXTENT_AXIS2: ext2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      pos0  <= '0;
      pos1  <= '0;
      pos2  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_TOT1;
          end
        end
        ST_TOT1: state <= ST_TOT2;
        ST_TOT2: state <= ST_CUR1;
        ST_CUR1: state <= ST_CUR2;
        ST_CUR2: begin
          if (mode_r == MODE_ADD || mode_r == MODE_SUB) begin
            state <= ST_ADD;
          end else if (chk_r) begin
            state <= ST_NEW1;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_NEW1: state <= ST_NEW2;
        ST_NEW2: state <= ST_FIN;
        ST_ADD: begin
          state <= f_bad ? ST_FIN : ST_DIV1;
        end
        ST_DIV1: begin
          if (cnt == '0) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (cnt == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          pos0  <= sel0;
          pos1  <= sel1;
          pos2  <= sel2;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mode_r   <= mode;
        stride_r <= stride;
        n0       <= step_n0;
        n1       <= step_n1;
        n2       <= step_n2;
        err_r    <= step_err;
        chk_r    <= (mode == MODE_LOAD) || (mode == MODE_FWD) || (mode == MODE_BACK);
        change_r <= (mode == MODE_LOAD) || (mode == MODE_FWD) || (mode == MODE_BACK)
                    || (mode == MODE_ADD) || (mode == MODE_SUB);
      end
      ST_TOT1: plane    <= alu_res[PLANE_W-1:0];
      ST_TOT2: total    <= alu_res;
      ST_CUR1: acc      <= alu_res[PLANE_W-1:0];
      ST_CUR2: flat_cur <= alu_res;
      ST_NEW1: acc      <= alu_res[PLANE_W-1:0];
      ST_NEW2: flat_new <= alu_res;
      ST_ADD: begin
        // new flat index is the divide's dividend
        err_r    <= f_bad;
        flat_new <= f_sum[FLAT_W-1:0];
        rem      <= f_sum[FLAT_W-1:0];
        dvs      <= {plane, 10'b0};
        quo      <= '0;
        cnt      <= CNT_LAST;
      end
      ST_DIV1: begin
        rem <= alu_res;
        if (cnt == '0) begin
          n0  <= quo_next;
          dvs <= {10'b0, e2, 10'b0};
          quo <= '0;
          cnt <= CNT_LAST;
        end else begin
          quo <= quo_next;
          dvs <= dvs >> 1;
          cnt <= cnt - 4'd1;
        end
      end
      ST_DIV2: begin
        rem <= alu_res;
        if (cnt == '0) begin
          n1 <= quo_next[AXIS_W-1:0];
          n2 <= alu_res[AXIS_W-1:0];
        end else begin
          quo <= quo_next;
          dvs <= dvs >> 1;
          cnt <= cnt - 4'd1;
        end
      end
      ST_FIN: begin
        pos_axis0     <= sel0;
        pos_axis1     <= sel1;
        pos_axis2     <= sel2;
        flat_position <= commit ? flat_new : flat_cur;
        in_grid       <= (sel0 < e0) && ({1'b0, sel1} < e1) && ({1'b0, sel2} < e2);
        range_error   <= err_fin;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/gidx_checker.sv
`include "grid_index_walker_assert.svh"

module gidx_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic                          range_error,
  input logic [gidx_pkg::FLAT_W-1:0]   flat_position
);
  import gidx_pkg::*;

  // result appears as the block goes idle
  `GIW_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `GIW_ASSERT_NOW(a_fell_done, $fell(busy) && !$past(rst), done, "item ended without result")
  // accepted item occupies the block
  `GIW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
  // one result per item, never back to back
  `GIW_ASSERT_NEXT(a_single_done, done, !done, "repeated result strobe")
  // flat_position and range_error are known whenever the strobe is up
  `GIW_ASSERT_NOW(a_out_known, done, !$isunknown({flat_position, range_error}), "result unknown")

endmodule

bind grid_index_walker gidx_checker u_gidx_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .range_error   (range_error),
  .flat_position (flat_position)
);

### tb/sv/tb_grid_index_walker.sv
module tb_grid_index_walker;
  timeunit 1ns;
  timeprecision 1ps;

  import gidx_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 500000;

  // modes the block must ignore
  localparam logic [MODE_W-1:0] MODE_UNDEF_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNDEF_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNDEF_C = 3'd7;

  typedef longint unsigned u64_t;
  typedef u64_t axes_t [3];

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [STRIDE_W-1:0] stride;
    logic [EXT_W-1:0]           load0;
    logic [AXIS_W-1:0]          load1;
    logic [AXIS_W-1:0]          load2;
  } walk_cmd_t;

  typedef struct packed {
    logic [EXT_W-1:0]  pos0;
    logic [AXIS_W-1:0] pos1;
    logic [AXIS_W-1:0] pos2;
    logic [FLAT_W-1:0] flat;
    logic              in_grid;
    logic              range_error;
  } walk_result_t;

  // one line of the opening sequence: either an extent write or a move
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [EXT_W-1:0]     reg_val;
    walk_cmd_t            cmd;
    logic                 typed;
    walk_result_t         res;
  } walk_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [MODE_W-1:0]      mode = '0;
  logic signed [STRIDE_W-1:0] stride = '0;
  logic [EXT_W-1:0]       load_axis0 = '0;
  logic [AXIS_W-1:0]      load_axis1 = '0;
  logic [AXIS_W-1:0]      load_axis2 = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [EXT_W-1:0]       cfg_data = '0;
  logic                   done;
  logic [EXT_W-1:0]       pos_axis0;
  logic [AXIS_W-1:0]      pos_axis1;
  logic [AXIS_W-1:0]      pos_axis2;
  logic [FLAT_W-1:0]      flat_position;
  logic                   in_grid;
  logic                   range_error;

  // shadow of the block: extent registers and current position
  logic [EXT_W-1:0] extent_regs [3];
  axes_t            grid_pos;

  walk_result_t pending_positions [$];
  walk_row_t    opening_moves [$];
  walk_result_t want;
  int           fail_count = 0;
  int           cycle_count = 0;

  grid_index_walker dut (.*);

  always #4 clk = ~clk;

  // register value to the extent actually used
  function automatic u64_t axis_extent(int axis);
    u64_t v;
    v = u64_t'(extent_regs[axis]);
    if (axis == 2 && NUM_AXES < 3) v = 1;
    else if (v == 0) v = 1;
    else if (v > MAX_EXTENT) v = MAX_EXTENT;
    return v;
  endfunction

  function automatic u64_t row_major_flat(axes_t p, axes_t e);
    return (p[0] * e[1] + p[1]) * e[2] + p[2];
  endfunction

  // apply one move to the shadow position and return the result it reports
  function automatic walk_result_t advance_walker(walk_cmd_t c);
    axes_t        e;
    axes_t        n;
    u64_t         total, plane, uf, fl;
    longint       f;
    logic         err, moved, carry;
    walk_result_t r;
    for (int i = 0; i < 3; i++) e[i] = axis_extent(i);
    total = e[0] * e[1] * e[2];
    n = grid_pos;
    err = 1'b0;
    moved = 1'b1;
    r = '0;
    case (c.mode)
      MODE_LOAD: begin
        n[0] = u64_t'(c.load0);
        n[1] = u64_t'(c.load1);
        n[2] = (NUM_AXES < 3) ? 64'd0 : u64_t'(c.load2);
        err = (n[1] >= e[1]) || (n[2] >= e[2]) || (row_major_flat(n, e) > total);
      end
      MODE_FWD: begin
        // an axis at or above extent-1 wraps and carries
        carry = 1'b1;
        for (int i = 2; i >= 1; i--) begin
          if (carry) begin
            if (n[i] + 1 >= e[i]) n[i] = 0;
            else begin
              n[i] = n[i] + 1;
              carry = 1'b0;
            end
          end
        end
        if (carry) n[0] = n[0] + 1;
        err = row_major_flat(n, e) > total;
      end
      MODE_BACK: begin
        // oversized axes come back to extent-1 first
        carry = 1'b1;
        for (int i = 2; i >= 1; i--) begin
          if (carry) begin
            if (n[i] == 0) n[i] = e[i] - 1;
            else begin
              n[i] = ((n[i] > e[i]) ? e[i] : n[i]) - 1;
              carry = 1'b0;
            end
          end
        end
        if (carry) begin
          if (n[0] == 0) err = 1'b1;
          else n[0] = n[0] - 1;
        end
        if (!err && row_major_flat(n, e) > total) err = 1'b1;
      end
      MODE_ADD, MODE_SUB: begin
        f = longint'(row_major_flat(grid_pos, e));
        f = (c.mode == MODE_ADD) ? f + longint'(signed'(c.stride))
                                 : f - longint'(signed'(c.stride));
        if (f < 0 || u64_t'(f) > total) err = 1'b1;
        else begin
          uf = u64_t'(f);
          plane = e[1] * e[2];
          n[0] = uf / plane;
          uf = uf % plane;
          n[1] = uf / e[2];
          n[2] = uf % e[2];
        end
      end
      default: moved = 1'b0;
    endcase
    if (moved && !err) grid_pos = n;
    fl = row_major_flat(grid_pos, e);
    r.pos0 = grid_pos[0][EXT_W-1:0];
    r.pos1 = grid_pos[1][AXIS_W-1:0];
    r.pos2 = grid_pos[2][AXIS_W-1:0];
    r.flat = fl[FLAT_W-1:0];
    r.in_grid = (grid_pos[0] < e[0]) && (grid_pos[1] < e[1]) && (grid_pos[2] < e[2]);
    r.range_error = err;
    return r;
  endfunction

  // random move, biased toward legal loads and strides that land inside
  function automatic walk_cmd_t rand_cmd();
    walk_cmd_t c;
    axes_t     e;
    u64_t      total, here;
    longint    target, delta;
    logic      aim;
    int        pick;
    for (int i = 0; i < 3; i++) e[i] = axis_extent(i);
    total = e[0] * e[1] * e[2];
    here = row_major_flat(grid_pos, e);
    c.stride = $urandom;
    c.load0 = EXT_W'($urandom);
    c.load1 = AXIS_W'($urandom);
    c.load2 = AXIS_W'($urandom);
    aim = 1'b0;
    target = 0;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      c.mode = MODE_LOAD;
      case ($urandom_range(0, 5))
        0: begin
          // one past the end
          c.load0 = EXT_W'(e[0]);
          c.load1 = 0;
          c.load2 = 0;
        end
        1: ; // raw bits, mostly refused
        2: begin
          c.load0 = EXT_W'($urandom_range(0, 32'(e[0] - 1)));
          c.load1 = AXIS_W'(e[1] - 1);
          c.load2 = AXIS_W'(e[2] - 1);
        end
        3: begin
          c.load0 = EXT_W'($urandom_range(0, 32'(e[0])));
          c.load1 = 0;
          c.load2 = 0;
        end
        default: begin
          c.load0 = EXT_W'($urandom_range(0, 32'(e[0] - 1)));
          c.load1 = AXIS_W'($urandom_range(0, 32'(e[1] - 1)));
          c.load2 = AXIS_W'($urandom_range(0, 32'(e[2] - 1)));
        end
      endcase
    end else if (pick < 42) begin
      c.mode = MODE_FWD;
    end else if (pick < 62) begin
      c.mode = MODE_BACK;
    end else if (pick < 92) begin
      c.mode = $urandom_range(0, 1) ? MODE_ADD : MODE_SUB;
      case ($urandom_range(0, 7))
        0: ; // full-range stride
        1: begin
          aim = 1'b1;
          target = longint'($urandom_range(0, 1) ? total : 0)
                   + longint'($urandom_range(0, 4)) - 2;
        end
        2, 3: c.stride = 32'(longint'($urandom_range(0, 140)) - 70);
        default: begin
          aim = 1'b1;
          target = longint'($urandom_range(0, 32'(total)));
        end
      endcase
      if (aim) begin
        delta = target - longint'(here);
        c.stride = (c.mode == MODE_ADD) ? 32'(delta) : 32'(-delta);
      end
    end else begin
      c.mode = MODE_W'($urandom_range(MODE_UNDEF_A, MODE_UNDEF_C));
    end
    return c;
  endfunction

  function automatic walk_row_t move_row(logic [MODE_W-1:0] m, logic [STRIDE_W-1:0] s,
                                         logic [EXT_W-1:0] a0, logic [AXIS_W-1:0] a1,
                                         logic [AXIS_W-1:0] a2);
    walk_row_t w;
    w = '0;
    w.cmd.mode = m;
    w.cmd.stride = s;
    w.cmd.load0 = a0;
    w.cmd.load1 = a1;
    w.cmd.load2 = a2;
    return w;
  endfunction

  function automatic walk_row_t checked_row(logic [MODE_W-1:0] m, logic [STRIDE_W-1:0] s,
                                            logic [EXT_W-1:0] a0, logic [AXIS_W-1:0] a1,
                                            logic [AXIS_W-1:0] a2, logic [EXT_W-1:0] p0,
                                            logic [AXIS_W-1:0] p1, logic [AXIS_W-1:0] p2,
                                            logic [FLAT_W-1:0] fl, logic ig, logic re);
    walk_row_t w;
    w = move_row(m, s, a0, a1, a2);
    w.typed = 1'b1;
    w.res.pos0 = p0;
    w.res.pos1 = p1;
    w.res.pos2 = p2;
    w.res.flat = fl;
    w.res.in_grid = ig;
    w.res.range_error = re;
    return w;
  endfunction

  function automatic walk_row_t extent_row(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
    walk_row_t w;
    w = '0;
    w.is_reg = 1'b1;
    w.reg_idx = idx;
    w.reg_val = val;
    return w;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // hold start until the block takes the transaction, then record the outcome
  task automatic send_cmd(walk_cmd_t c, logic typed, walk_result_t typed_res);
    walk_result_t r;
    start <= 1'b1;
    mode <= c.mode;
    stride <= c.stride;
    load_axis0 <= c.load0;
    load_axis1 <= c.load1;
    load_axis2 <= c.load2;
    do @(posedge clk); while (busy);
    r = advance_walker(c);
    pending_positions.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_positions.size() != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; caller lowers it
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    extent_regs[idx] = val;
  endtask

  // result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_positions.size() == 0) begin
        $error("result with nothing outstanding: pos %0d/%0d/%0d flat %0d",
               pos_axis0, pos_axis1, pos_axis2, flat_position);
        fail_count++;
      end else begin
        want = pending_positions.pop_front();
        check_field("pos_axis0", 64'(want.pos0), 64'(pos_axis0));
        check_field("pos_axis1", 64'(want.pos1), 64'(pos_axis1));
        check_field("pos_axis2", 64'(want.pos2), 64'(pos_axis2));
        check_field("flat_position", 64'(want.flat), 64'(flat_position));
        check_field("in_grid", 64'(want.in_grid), 64'(in_grid));
        check_field("range_error", 64'(want.range_error), 64'(range_error));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_grid_index_walker: FAIL");
      $finish;
    end
  end

  initial begin
    walk_row_t        row;
    walk_result_t     none;
    logic [EXT_W-1:0] x0, x1, x2;
    int               gap_pct;
    for (int i = 0; i < 3; i++) begin
      extent_regs[i] = 1;
      grid_pos[i] = 0;
    end
    none = '0;

    // all extents 1: one cell, then one past the end
    opening_moves.push_back(checked_row(MODE_FWD, 0, 0, 0, 0, 1, 0, 0, 1, 1'b0, 1'b0));
    opening_moves.push_back(checked_row(MODE_FWD, 0, 0, 0, 0, 1, 0, 0, 1, 1'b0, 1'b1));
    opening_moves.push_back(checked_row(MODE_BACK, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    // back step from the origin must be refused
    opening_moves.push_back(checked_row(MODE_BACK, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    opening_moves.push_back(checked_row(MODE_UNDEF_A, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    opening_moves.push_back(checked_row(MODE_ADD, 1, 0, 0, 0, 1, 0, 0, 1, 1'b0, 1'b0));
    opening_moves.push_back(checked_row(MODE_SUB, 2, 0, 0, 0, 1, 0, 0, 1, 1'b0, 1'b1));
    opening_moves.push_back(checked_row(MODE_ADD, 32'h8000_0000, 0, 0, 0,
                                        1, 0, 0, 1, 1'b0, 1'b1));
    // loads outside the grid, then a legal load back to the origin
    opening_moves.push_back(checked_row(MODE_LOAD, 0, 0, 1, 0, 1, 0, 0, 1, 1'b0, 1'b1));
    opening_moves.push_back(checked_row(MODE_LOAD, 0, 2047, 1023, 1023,
                                        1, 0, 0, 1, 1'b0, 1'b1));
    opening_moves.push_back(checked_row(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    opening_moves.push_back(checked_row(MODE_UNDEF_C, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    // 3x4x5 grid, total 60
    opening_moves.push_back(extent_row(REG_EXTENT_AXIS0, 3));
    opening_moves.push_back(extent_row(REG_EXTENT_AXIS1, 4));
    opening_moves.push_back(extent_row(REG_EXTENT_AXIS2, 5));
    opening_moves.push_back(checked_row(MODE_LOAD, 0, 3, 0, 0, 3, 0, 0, 60, 1'b0, 1'b0));
    opening_moves.push_back(checked_row(MODE_FWD, 0, 0, 0, 0, 3, 0, 0, 60, 1'b0, 1'b1));
    opening_moves.push_back(checked_row(MODE_BACK, 0, 0, 0, 0, 2, 3, 4, 59, 1'b1, 1'b0));
    opening_moves.push_back(move_row(MODE_FWD, 0, 0, 0, 0));
    opening_moves.push_back(move_row(MODE_SUB, 60, 0, 0, 0));
    opening_moves.push_back(move_row(MODE_ADD, 32'h4000_0000, 0, 0, 0));
    opening_moves.push_back(move_row(MODE_ADD, 37, 0, 0, 0));
    opening_moves.push_back(move_row(MODE_ADD, -2, 0, 0, 0));
    // shrink axis 1 under a position that now sits outside it
    opening_moves.push_back(extent_row(REG_EXTENT_AXIS1, 2));
    opening_moves.push_back(move_row(MODE_UNDEF_B, 0, 0, 0, 0));
    opening_moves.push_back(move_row(MODE_BACK, 0, 0, 0, 0));
    // shrink axis 2 so a forward step carries out of an oversized axis
    opening_moves.push_back(extent_row(REG_EXTENT_AXIS2, 1));
    opening_moves.push_back(move_row(MODE_FWD, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // opening sequence
    foreach (opening_moves[k]) begin
      row = opening_moves[k];
      if (row.is_reg) begin
        start <= 1'b0;
        wait_idle();
        put_reg(row.reg_idx, row.reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_cmd(row.cmd, row.typed, row.res);
      end
    end

    // random phases, each under its own grid shape
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: {x0, x1, x2} = {11'd3, 11'd4, 11'd5};
        1: {x0, x1, x2} = {11'd0, 11'd2047, 11'd0};
        2: {x0, x1, x2} = {11'd2, 11'd1, 11'd7};
        3: {x0, x1, x2} = {11'd2047, 11'd2047, 11'd2047};
        4: {x0, x1, x2} = {11'd1025, 11'd1024, 11'd1023};
        5: {x0, x1, x2} = {11'd1, 11'd1, 11'd1};
        6, 7: begin
          x0 = EXT_W'($urandom_range(0, 9));
          x1 = EXT_W'($urandom_range(0, 9));
          x2 = EXT_W'($urandom_range(0, 9));
        end
        8: begin
          x0 = EXT_W'($urandom);
          x1 = EXT_W'($urandom);
          x2 = EXT_W'($urandom);
        end
        default: {x0, x1, x2} = {11'd5, 11'd6, 11'd2};
      endcase
      start <= 1'b0;
      wait_idle();
      put_reg(REG_EXTENT_AXIS0, x0);
      put_reg(REG_EXTENT_AXIS1, x1);
      put_reg(REG_EXTENT_AXIS2, x2);
      cfg_valid <= 1'b0;
      // some phases run back to back, and the last one always does
      gap_pct = (ph == NUM_PHASES - 1 || ph % 4 == 2) ? 0 : 15;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < gap_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        send_cmd(rand_cmd(), 1'b0, none);
      end
    end

    // drain
    start <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_grid_index_walker: PASS");
    end else begin
      $display("tb_grid_index_walker: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/gidx_pkg.sv
rtl/gidx_alu.sv
rtl/grid_index_walker.sv
rtl/gidx_checker.sv
tb/sv/tb_grid_index_walker.sv
